// ----- rtl/spd_pkg.sv -----
package spd_pkg;

  // Configuration register indexes (byte address = 4 * index)
  localparam logic [2:0] REG_STREAM_FORMAT   = 3'd0;
  localparam logic [2:0] REG_DEVICE_ENABLED  = 3'd1;
  localparam logic [2:0] REG_INPUT_ENABLE    = 3'd2;
  localparam logic [2:0] REG_STOP_FLAG       = 3'd3;
  localparam logic [2:0] REG_PLAYBACK_ENABLE = 3'd4;
  localparam logic [2:0] REG_MUTED           = 3'd5;

  localparam int unsigned PADDR_W = 5;

  // Format codes, stream_format bits 7:5
  localparam logic [2:0] FMT_ADPCM     = 3'b000;
  localparam logic [2:0] FMT_PCM8      = 3'b010;
  localparam logic [2:0] FMT_PCM16     = 3'b011;
  localparam logic [2:0] FMT_PCM16_ALT = 3'b111;

  // Step size limits
  localparam logic [14:0] STEP_MIN = 15'd127;
  localparam logic [14:0] STEP_MAX = 15'd24576;

  // Step scale factor per nibble magnitude (in 1/256 units)
  function automatic logic [9:0] step_scale(input logic [2:0] m);
    logic [9:0] s;
    begin
      case (m)
        3'd4:    s = 10'd307;
        3'd5:    s = 10'd409;
        3'd6:    s = 10'd512;
        3'd7:    s = 10'd614;
        default: s = 10'd230;
      endcase
      return s;
    end
  endfunction

endpackage

// ----- rtl/spd_if.sv -----
// Input channel: one speaker byte or a decoder reset per transaction
interface spd_in_if;
  logic       valid;
  logic       ready;
  logic       command;
  logic [7:0] data_byte;
  logic       end_of_write;

  modport source (output valid, output command, output data_byte, output end_of_write,
                  input ready);
  modport sink (input valid, input command, input data_byte, input end_of_write,
                output ready);
endinterface

// Output channel: one decoded sample per transaction
interface spd_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] sample;
  logic               last;

  modport source (output valid, output sample, output last, input ready);
  modport sink (input valid, input sample, input last, output ready);
endinterface

// ----- rtl/speaker_adpcm_pcm_decoder.sv -----
// Speaker sample decoder. Each input transaction carries a speaker data byte or a
// decoder reset command; output transactions carry signed 16-bit samples, with last
// set on the final sample of an input. Bits 7:5 of stream_format select 4-bit ADPCM
// (two samples per byte, high nibble first), signed 8-bit PCM, or 16-bit
// little-endian PCM paired within one bus write. An ADPCM byte goes a nibble at a time
// through the shared predictor/step update unit; other inputs go in one pass, back to
// back unless the output stalls. An output register decouples the sink, so a new input
// is taken while a finished sample waits. Configuration goes through the APB port at 4*index.
module speaker_adpcm_pcm_decoder
  import spd_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  spd_in_if.sink             din,
  spd_out_if.source          dout
);

  // Configuration registers
  logic [7:0] stream_format;
  logic       device_enabled;
  logic       input_enable;
  logic       stop_flag;
  logic       playback_enable;
  logic       muted;

  // Decoder state
  logic signed [15:0] predictor;
  logic [14:0]        step_size;
  logic [7:0]         held_low_byte;
  logic               byte_pending;

  // Work stage
  logic       s_valid;
  logic       s_phase;
  logic       s_command;
  logic [7:0] s_byte;
  logic       s_eow;

  // Output register
  logic               o_valid;
  logic signed [15:0] o_sample;
  logic               o_last;

  logic [2:0]  fmt;
  logic        gated;
  logic        is_adpcm;
  logic [3:0]  nibble;
  logic [18:0] diff_mag;
  logic [15:0] diff_q;
  logic signed [17:0] pred_sum;
  logic signed [15:0] pred_new;
  logic [24:0] step_prod;
  logic [16:0] step_raw;
  logic [14:0] step_new;

  logic               has_sample;
  logic signed [15:0] sample_val;
  logic               sample_last;
  logic               emit;
  logic               can_go;
  logic               fire;
  logic               done;
  logic               accept;

  logic signed [15:0] predictor_next;
  logic [14:0]        step_size_next;
  logic               byte_pending_next;
  logic               hold_write;

  // APB port
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      stream_format   <= '0;
      device_enabled  <= 1'b0;
      input_enable    <= 1'b0;
      stop_flag       <= 1'b0;
      playback_enable <= 1'b0;
      muted           <= 1'b0;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[PADDR_W-1:2])
        REG_STREAM_FORMAT:   stream_format   <= pwdata[7:0];
        REG_DEVICE_ENABLED:  device_enabled  <= pwdata[0];
        REG_INPUT_ENABLE:    input_enable    <= pwdata[0];
        REG_STOP_FLAG:       stop_flag       <= pwdata[0];
        REG_PLAYBACK_ENABLE: playback_enable <= pwdata[0];
        REG_MUTED:           muted           <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (paddr[PADDR_W-1:2])
      REG_STREAM_FORMAT:   prdata = {24'd0, stream_format};
      REG_DEVICE_ENABLED:  prdata = {31'd0, device_enabled};
      REG_INPUT_ENABLE:    prdata = {31'd0, input_enable};
      REG_STOP_FLAG:       prdata = {31'd0, stop_flag};
      REG_PLAYBACK_ENABLE: prdata = {31'd0, playback_enable};
      REG_MUTED:           prdata = {31'd0, muted};
      default:             prdata = '0;
    endcase
  end

  // Nibble expansion: predictor and step update
  assign fmt      = stream_format[7:5];
  assign gated    = stop_flag || !input_enable;
  assign is_adpcm = device_enabled && !s_command && !gated && (fmt == FMT_ADPCM);
  assign nibble   = s_phase ? s_byte[3:0] : s_byte[7:4];

  assign diff_mag = step_size * {nibble[2:0], 1'b1};
  assign diff_q   = diff_mag[18:3];
  assign pred_sum = nibble[3] ? ({{2{predictor[15]}}, predictor} - $signed({2'b00, diff_q}))
                              : ({{2{predictor[15]}}, predictor} + $signed({2'b00, diff_q}));

  always_comb begin
    if (pred_sum > 18'sd32767) begin
      pred_new = 16'sh7fff;
    end else if (pred_sum < -18'sd32768) begin
      pred_new = 16'sh8000;
    end else begin
      pred_new = pred_sum[15:0];
    end
  end

  assign step_prod = step_size * step_scale(nibble[2:0]);
  assign step_raw  = step_prod[24:8];

  always_comb begin
    if (step_raw < {2'b00, STEP_MIN}) begin
      step_new = STEP_MIN;
    end else if (step_raw > {2'b00, STEP_MAX}) begin
      step_new = STEP_MAX;
    end else begin
      step_new = step_raw[14:0];
    end
  end

  // Per-step result and state update
  always_comb begin
    predictor_next    = predictor;
    step_size_next    = step_size;
    byte_pending_next = byte_pending;
    hold_write        = 1'b0;
    has_sample        = 1'b0;
    sample_val        = pred_new;
    sample_last       = 1'b1;
    if (device_enabled) begin
      if (s_command) begin
        predictor_next    = '0;
        step_size_next    = '0;
        byte_pending_next = 1'b0;
      end else if (!gated) begin
        case (fmt) inside
          FMT_ADPCM: begin
            byte_pending_next = 1'b0;
            predictor_next    = pred_new;
            step_size_next    = step_new;
            has_sample        = 1'b1;
            sample_val        = pred_new;
            sample_last       = s_phase;
          end
          FMT_PCM8: begin
            byte_pending_next = 1'b0;
            has_sample        = 1'b1;
            sample_val        = {s_byte, 8'h00};
          end
          FMT_PCM16, FMT_PCM16_ALT: begin
            if (byte_pending) begin
              has_sample        = 1'b1;
              sample_val        = {s_byte, held_low_byte};
              byte_pending_next = 1'b0;
            end else begin
              hold_write        = 1'b1;
              byte_pending_next = !s_eow;
            end
          end
          default: byte_pending_next = 1'b0;
        endcase
      end
      if (!s_command && s_eow) begin
        byte_pending_next = 1'b0;
      end
    end
  end

  // Handshake: advance when the result has room or there is none
  assign emit   = has_sample && playback_enable && !muted && !stream_format[0];
  assign can_go = !emit || !o_valid || dout.ready;
  assign fire   = s_valid && can_go;
  assign done   = fire && !(is_adpcm && !s_phase);
  assign din.ready = !s_valid || done;
  assign accept = din.valid && din.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid      <= 1'b0;
      s_phase      <= 1'b0;
      predictor    <= '0;
      step_size    <= '0;
      byte_pending <= 1'b0;
    end else begin
      if (accept) begin
        s_valid <= 1'b1;
        s_phase <= 1'b0;
      end else if (done) begin
        s_valid <= 1'b0;
        s_phase <= 1'b0;
      end else if (fire) begin
        s_phase <= 1'b1;
      end
      if (fire) begin
        predictor    <= predictor_next;
        step_size    <= step_size_next;
        byte_pending <= byte_pending_next;
      end
    end
  end

  // Hold the accepted item and the low byte of a 16-bit pair
  always_ff @(posedge clk) begin
    if (accept) begin
      s_command <= din.command;
      s_byte    <= din.data_byte;
      s_eow     <= din.end_of_write;
    end
    if (fire && hold_write) begin
      held_low_byte <= s_byte;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (fire && emit) begin
      o_valid <= 1'b1;
    end else if (dout.ready) begin
      o_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && emit) begin
      o_sample <= sample_val;
      o_last   <= sample_last;
    end
  end

  assign dout.valid  = o_valid;
  assign dout.sample = o_sample;
  assign dout.last   = o_last;

endmodule
